// ===== rtl/dpr_pkg.sv =====
// Package with shared constants for the direction placement block.
`timescale 1ns / 1ps
package dpr_pkg;
  localparam int LANES        = 3;
  localparam int RADIUS_W     = 16;
  localparam int RADIUS_RESET = 100;
endpackage

// ===== rtl/dpr_sqrt_cell.sv =====
// One cell of the square root chain: settles one result bit per cell.
`timescale 1ns / 1ps
module dpr_sqrt_cell #(
  parameter int SUM_W  = 70,
  parameter int ROOT_W = 34,
  parameter int BIT    = 0,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_sum,
  input  logic [ROOT_W-1:0] in_root,
  input  logic [SUM_W-1:0]  in_root_sq,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [SUM_W-1:0]  out_sum,
  output logic [ROOT_W-1:0] out_root,
  output logic [SUM_W-1:0]  out_root_sq,
  output logic [SIDE_W-1:0] out_side
);
  logic [SUM_W-1:0] cand_sq;
  logic             take;

  // (r + 2^b)^2 = r^2 + r*2^(b+1) + 2^(2b)
  assign cand_sq = in_root_sq + (SUM_W'(in_root) << (BIT + 1)) + (SUM_W'(1) << (2 * BIT));
  assign take    = (cand_sq <= in_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sum     <= in_sum;
      out_side    <= in_side;
      out_root    <= take ? (in_root | (ROOT_W'(1) << BIT)) : in_root;
      out_root_sq <= take ? cand_sq : in_root_sq;
    end
  end
endmodule

// ===== rtl/dpr_div_cell.sv =====
// One cell of the division chain: settles one quotient bit for each axis.
`timescale 1ns / 1ps
module dpr_div_cell #(
  parameter int NUM_W  = 57,
  parameter int LEN_W  = 34,
  parameter int Q_W    = 24,
  parameter int BIT    = 0,
  parameter int SIDE_W = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [LEN_W-1:0]                    in_len,
  input  logic [dpr_pkg::LANES-1:0][NUM_W-1:0] in_rem,
  input  logic [dpr_pkg::LANES-1:0][Q_W-1:0]   in_quot,
  input  logic [SIDE_W-1:0]                   in_side,
  output logic                                out_valid,
  output logic [LEN_W-1:0]                    out_len,
  output logic [dpr_pkg::LANES-1:0][NUM_W-1:0] out_rem,
  output logic [dpr_pkg::LANES-1:0][Q_W-1:0]   out_quot,
  output logic [SIDE_W-1:0]                   out_side
);
  logic [NUM_W-1:0] divisor;

  assign divisor = NUM_W'(in_len) << BIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_len  <= in_len;
      out_side <= in_side;
      for (int i = 0; i < dpr_pkg::LANES; i++) begin
        if (in_rem[i] >= divisor) begin
          out_rem[i]  <= in_rem[i] - divisor;
          out_quot[i] <= in_quot[i] | (Q_W'(1) << BIT);
        end else begin
          out_rem[i]  <= in_rem[i];
          out_quot[i] <= in_quot[i];
        end
      end
    end
  end
endmodule

// ===== rtl/direction_place_at_radius.sv =====
// Top level: places a source on a sphere of configured radius around the listener.
// Path: difference, square and sum registers, square root chain, numerator register, divide chain, output register.
// Throughput: one word per cycle; every stage is a register in one shared enable chain.
// The chain holds while the output register is full and not taken.
// The square root chain has COORD_WIDTH+2 cells, the divide chain 16+FRAC_BITS cells.
// Reset (rst, synchronous) empties the pipe and sets the radius to 100.
`timescale 1ns / 1ps
module direction_place_at_radius #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dpr_pkg::RADIUS_W-1:0]     cfg_wdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // source_x, source_y, source_z, listener_x, listener_y, listener_z
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // is_own_station
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // placed_x, placed_y, placed_z
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
  localparam int CW     = COORD_WIDTH;
  localparam int LN     = dpr_pkg::LANES;
  localparam int MW     = CW + 1;
  localparam int SUMW   = 2 * MW + 2;
  localparam int RW     = CW + 2;
  localparam int KW     = dpr_pkg::RADIUS_W + FRAC_BITS;
  localparam int NW     = MW + KW;
  localparam int AW     = ((CW > KW) ? CW : KW) + 2;
  localparam int OUT_W  = ((3*CW+7)/8)*8;
  localparam int SQ_SW  = 1 + LN + LN*MW + LN*CW;
  localparam int DV_SW  = 2 + LN + LN*CW;

  logic en;
  logic [dpr_pkg::RADIUS_W-1:0] radius;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= dpr_pkg::RADIUS_W'(dpr_pkg::RADIUS_RESET);
    end else if (cfg_we) begin
      radius <= cfg_wdata;
    end
  end

  // stage 1: differences
  logic                      v1, own1;
  logic [LN-1:0]             sgn1;
  logic [LN-1:0][MW-1:0]     mag1;
  logic [LN-1:0][CW-1:0]     lis1;
  logic [LN-1:0][MW-1:0]     diff;

  always_comb begin
    for (int i = 0; i < LN; i++) begin
      diff[i] = {s_axis_tdata[i*CW+CW-1], s_axis_tdata[i*CW +: CW]}
              - {s_axis_tdata[(i+LN)*CW+CW-1], s_axis_tdata[(i+LN)*CW +: CW]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      own1 <= s_axis_tuser;
      for (int i = 0; i < LN; i++) begin
        sgn1[i] <= diff[i][MW-1];
        mag1[i] <= diff[i][MW-1] ? (~diff[i] + MW'(1)) : diff[i];
        lis1[i] <= s_axis_tdata[(i+LN)*CW +: CW];
      end
    end
  end

  // stage 2: squares
  logic                      v2, own2;
  logic [LN-1:0]             sgn2;
  logic [LN-1:0][MW-1:0]     mag2;
  logic [LN-1:0][CW-1:0]     lis2;
  logic [LN-1:0][2*MW-1:0]   sq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      own2 <= own1;
      sgn2 <= sgn1;
      mag2 <= mag1;
      lis2 <= lis1;
      for (int i = 0; i < LN; i++) begin
        sq2[i] <= mag1[i] * mag1[i];
      end
    end
  end

  // stage 3: sum of squares
  logic              v3;
  logic [SUMW-1:0]   sum3;
  logic [SQ_SW-1:0]  side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum3  <= SUMW'(sq2[0]) + SUMW'(sq2[1]) + SUMW'(sq2[2]);
      side3 <= {own2, sgn2, mag2, lis2};
    end
  end

  // square root chain
  logic              sq_v    [0:RW];
  logic [SUMW-1:0]   sq_s    [0:RW];
  logic [RW-1:0]     sq_r    [0:RW];
  logic [SUMW-1:0]   sq_r2   [0:RW];
  logic [SQ_SW-1:0]  sq_side [0:RW];

  assign sq_v[0]    = v3;
  assign sq_s[0]    = sum3;
  assign sq_r[0]    = '0;
  assign sq_r2[0]   = '0;
  assign sq_side[0] = side3;

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    dpr_sqrt_cell #(
      .SUM_W (SUMW),
      .ROOT_W(RW),
      .BIT   (RW - 1 - j),
      .SIDE_W(SQ_SW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .in_valid   (sq_v[j]),
      .in_sum     (sq_s[j]),
      .in_root    (sq_r[j]),
      .in_root_sq (sq_r2[j]),
      .in_side    (sq_side[j]),
      .out_valid  (sq_v[j+1]),
      .out_sum    (sq_s[j+1]),
      .out_root   (sq_r[j+1]),
      .out_root_sq(sq_r2[j+1]),
      .out_side   (sq_side[j+1])
    );
  end

  // stage M: numerators mag * K
  logic                  own_q, vm;
  logic [LN-1:0]         sgn_q;
  logic [LN-1:0][MW-1:0] mag_q;
  logic [LN-1:0][CW-1:0] lis_q;
  logic [KW-1:0]         kval;
  logic [RW-1:0]         len_m;
  logic [LN-1:0][NW-1:0] num_m;
  logic [DV_SW-1:0]      side_m;

  assign {own_q, sgn_q, mag_q, lis_q} = sq_side[RW];
  assign kval = KW'(radius) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= sq_v[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len_m  <= sq_r[RW];
      side_m <= {own_q, (sq_r[RW] == '0), sgn_q, lis_q};
      for (int i = 0; i < LN; i++) begin
        num_m[i] <= NW'(mag_q[i]) * NW'(kval);
      end
    end
  end

  // divide chain
  logic                  dv_v    [0:KW];
  logic [RW-1:0]         dv_len  [0:KW];
  logic [LN-1:0][NW-1:0] dv_rem  [0:KW];
  logic [LN-1:0][KW-1:0] dv_q    [0:KW];
  logic [DV_SW-1:0]      dv_side [0:KW];

  assign dv_v[0]    = vm;
  assign dv_len[0]  = len_m;
  assign dv_rem[0]  = num_m;
  assign dv_q[0]    = '0;
  assign dv_side[0] = side_m;

  for (genvar j = 0; j < KW; j++) begin : g_div
    dpr_div_cell #(
      .NUM_W (NW),
      .LEN_W (RW),
      .Q_W   (KW),
      .BIT   (KW - 1 - j),
      .SIDE_W(DV_SW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (dv_v[j]),
      .in_len   (dv_len[j]),
      .in_rem   (dv_rem[j]),
      .in_quot  (dv_q[j]),
      .in_side  (dv_side[j]),
      .out_valid(dv_v[j+1]),
      .out_len  (dv_len[j+1]),
      .out_rem  (dv_rem[j+1]),
      .out_quot (dv_q[j+1]),
      .out_side (dv_side[j+1])
    );
  end

  // final add, saturate and select
  logic                  own_f, zero_f;
  logic [LN-1:0]         sgn_f;
  logic [LN-1:0][CW-1:0] lis_f;
  logic [LN-1:0][AW-1:0] tot;
  logic [LN-1:0][AW-1:0] off;
  logic [LN-1:0][CW-1:0] placed;

  assign {own_f, zero_f, sgn_f, lis_f} = dv_side[KW];

  always_comb begin
    for (int i = 0; i < LN; i++) begin
      off[i] = sgn_f[i] ? (AW'(0) - AW'(dv_q[KW][i])) : AW'(dv_q[KW][i]);
      tot[i] = AW'($signed(lis_f[i])) + off[i];
      if (own_f || zero_f) begin
        placed[i] = lis_f[i];
      end else if (tot[i][AW-1:CW-1] == '0 || tot[i][AW-1:CW-1] == '1) begin
        placed[i] = tot[i][CW-1:0];
      end else begin
        placed[i] = {tot[i][AW-1], {(CW-1){~tot[i][AW-1]}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_v[KW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= OUT_W'({placed[2], placed[1], placed[0]});
    end
  end
endmodule

// ===== rtl/dpr_checker.sv =====
// Port-level checker for the direction placement block, with its bind.
`timescale 1ns / 1ps
module dpr_checker #(
  parameter int OUT_W = 96
) (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output empty");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");
endmodule

bind direction_place_at_radius dpr_checker #(
  .OUT_W(((3*COORD_WIDTH+7)/8)*8)
) u_dpr_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
